### hdl/psdt_pkg.sv
// shared types, constants and pattern tables for the pattern stamp table
package psdt_pkg;

    localparam int TableDepth    = 512;
    localparam int ScatterTarget = 10;
    localparam int ScatterTries  = 100;

    localparam logic [31:0] LcgMul  = 32'd1103515245;
    localparam logic [31:0] LcgInc  = 32'd12345;
    localparam logic [31:0] SeedRst = 32'd1;

    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_RING    = 3'd1,
        OP_LINE    = 3'd2,
        OP_STAR    = 3'd3,
        OP_TRI     = 3'd4,
        OP_SCATTER = 3'd5
    } t_op;

    typedef struct packed {
        logic signed [2:0] dc;
        logic signed [2:0] dr;
        logic              half;
    } t_offset;

    // number of offsets stamped by an operation
    function automatic logic [3:0] pattern_len(input logic [2:0] op);
        case (op)
            OP_RING: pattern_len = 4'd6;
            OP_LINE: pattern_len = 4'd8;
            OP_STAR: pattern_len = 4'd12;
            OP_TRI:  pattern_len = 4'd4;
            default: pattern_len = 4'd0;
        endcase
    endfunction

    function automatic t_offset mk(input int c, input int r, input int h);
        t_offset o;
        o.dc   = 3'(c);
        o.dr   = 3'(r);
        o.half = 1'(h);
        return o;
    endfunction

    function automatic t_offset pattern_offset(input logic [2:0] op, input logic [3:0] idx);
        t_offset o;
        o = mk(0, 0, 0);
        case (op)
            OP_LINE: o = mk(int'(idx[3:1]), 0, int'(idx[0]));
            OP_TRI: begin
                case (idx)
                    4'd0:    o = mk(0, 0, 0);
                    4'd1:    o = mk(0, 0, 1);
                    4'd2:    o = mk(1, 0, 0);
                    default: o = mk(0, 1, 1);
                endcase
            end
            default: begin
                case (idx)
                    4'd0:    o = mk(0, 0, 0);
                    4'd1:    o = mk(0, 0, 1);
                    4'd2:    o = mk(-1, 0, 1);
                    4'd3:    o = mk(1, 0, 0);
                    4'd4:    o = mk(0, -1, 1);
                    4'd5:    o = mk(0, 1, 0);
                    4'd6:    o = mk(-1, -1, 1);
                    4'd7:    o = mk(1, -1, 0);
                    4'd8:    o = mk(-1, 1, 1);
                    4'd9:    o = mk(1, 1, 0);
                    4'd10:   o = mk(-2, 0, 1);
                    default: o = mk(2, 0, 0);
                endcase
            end
        endcase
        return o;
    endfunction

    // (x*9)/32767 for a 15-bit x, done with compare: result 0..9
    function automatic logic [3:0] scale9(input logic [14:0] x);
        logic [18:0] p;
        logic [3:0]  q;
        p = 19'(x) * 19'd9;
        q = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (p >= 19'(k * 32767)) q = 4'(k);
        end
        return q;
    endfunction

endpackage

### hdl/pattern_stamp_dedup_table.sv
// pattern stamp table: one command at a time, one stored entry scanned per cycle
// each stamp candidate is generated, scanned against every stored entry, checked,
// then emitted or dropped; a scatter try first takes its three draws
// a command is accepted only in idle, so one command is handled at a time;
// each command ends with a status item (a scatter on a full table runs all its tries)
// reset: entry count to zero, random seed to one; memory contents are not cleared
module pattern_stamp_dedup_table #(
    parameter int TABLE_DEPTH    = psdt_pkg::TableDepth,
    parameter int SCATTER_TARGET = psdt_pkg::ScatterTarget,
    parameter int SCATTER_TRIES  = psdt_pkg::ScatterTries
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[2:0], cursor_col[18:3], cursor_row[34:19], glyph[42:35],
    // entropy[74:43], zero fill
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // placed_col[15:0], placed_row[31:16], placed_half[32], placed_glyph[40:33],
    // entry_count[50:41], zero fill
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import psdt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;
    localparam int TW = $clog2(SCATTER_TRIES + 1);
    localparam int GW = $clog2(SCATTER_TARGET + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_GEN   = 7'b0000010,
        S_DRAW  = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_CHECK = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state         r_state;
    logic [2:0]     r_op;
    logic [15:0]    r_cc, r_cr;
    logic [7:0]     r_glyph;
    logic [3:0]     r_idx;
    logic [TW-1:0]  r_tries;
    logic [GW-1:0]  r_left;
    logic [1:0]     r_draw;
    logic [3:0]     r_dc, r_dr;
    logic [15:0]    r_col, r_row;
    logic           r_half;
    logic [CW-1:0]  r_total;
    logic [CW-1:0]  r_scan;
    logic           r_rd_vld;
    logic           r_hit;
    logic [40:0]    r_rd;
    logic [40:0]    r_mem [TABLE_DEPTH];
    logic           r_ovld;
    logic [55:0]    r_odata;
    logic           r_olast;

    logic           lcg_mix, lcg_step;
    logic [14:0]    lcg_x;
    t_offset        off;
    logic           out_free;
    logic           out_load;

    psdt_lcg u_lcg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mix     (lcg_mix),
        .i_entropy (s_axis_tdata[74:43]),
        .i_step    (lcg_step),
        .o_x       (lcg_x)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free      = !r_ovld || m_axis_tready;
    assign out_load      = out_free && (r_state == S_EMIT || r_state == S_DONE);
    assign lcg_mix       = s_axis_tvalid && s_axis_tready && s_axis_tdata[2:0] == OP_SCATTER;
    assign lcg_step      = (r_state == S_DRAW);
    assign off           = pattern_offset(r_op, r_idx);

    // synchronous read, one entry per cycle
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_scan[AW-1:0]];
        if (r_state == S_EMIT && out_free) begin
            r_mem[r_total[AW-1:0]] <= {r_glyph, r_half, r_row, r_col};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (out_load) begin
            r_ovld <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_SCAN) && (r_scan < r_total);
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op    <= s_axis_tdata[2:0];
                        r_cc    <= s_axis_tdata[18:3];
                        r_cr    <= s_axis_tdata[34:19];
                        r_glyph <= s_axis_tdata[42:35];
                        r_idx   <= '0;
                        r_tries <= '0;
                        r_left  <= GW'(SCATTER_TARGET);
                        r_draw  <= '0;
                        if (s_axis_tdata[2:0] == OP_CLEAR) r_total <= '0;
                        r_state <= (s_axis_tdata[2:0] == OP_SCATTER) ? S_DRAW : S_GEN;
                    end
                end
                S_GEN: begin
                    if (r_idx < pattern_len(r_op)) begin
                        r_col   <= r_cc + 16'(signed'(off.dc));
                        r_row   <= r_cr + 16'(signed'(off.dr));
                        r_half  <= off.half;
                        r_idx   <= r_idx + 4'd1;
                        r_scan  <= '0;
                        r_hit   <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DRAW: begin
                    if (r_draw == 2'd0) r_dc <= scale9(lcg_x);
                    if (r_draw == 2'd1) r_dr <= scale9(lcg_x);
                    if (r_draw == 2'd2) begin
                        r_col   <= r_cc + 16'(r_dc) - 16'd4;
                        r_row   <= r_cr + 16'(r_dr) - 16'd4;
                        r_half  <= lcg_x[14];
                        r_draw  <= '0;
                        r_scan  <= '0;
                        r_hit   <= 1'b0;
                        r_tries <= r_tries + TW'(1);
                        r_state <= S_SCAN;
                    end else begin
                        r_draw <= r_draw + 2'd1;
                    end
                end
                S_SCAN: begin
                    if (r_rd_vld && r_rd[32:0] == {r_half, r_row, r_col}) r_hit <= 1'b1;
                    if (r_scan < r_total) begin
                        r_scan <= r_scan + CW'(1);
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_rd_vld && r_rd[32:0] == {r_half, r_row, r_col}) r_hit <= 1'b1;
                    if (!r_rd_vld) begin
                        if (!r_hit && r_total < CW'(TABLE_DEPTH)) r_state <= S_EMIT;
                        else if (r_op == OP_SCATTER)
                            r_state <= (r_tries >= TW'(SCATTER_TRIES)) ? S_DONE : S_DRAW;
                        else r_state <= S_GEN;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_olast <= 1'b0;
                        r_odata <= {5'd0, 10'(r_total + CW'(1)), r_glyph, r_half, r_row, r_col};
                        r_total <= r_total + CW'(1);
                        if (r_op == OP_SCATTER) begin
                            r_left <= r_left - GW'(1);
                            r_state <= (r_left == GW'(1) || r_tries >= TW'(SCATTER_TRIES))
                                       ? S_DONE : S_DRAW;
                        end else begin
                            r_state <= S_GEN;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_olast <= 1'b1;
                        r_odata <= {5'd0, 10'(r_total), 41'd0};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(TABLE_DEPTH)) else $error("entry count over depth");
    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && out_free |=> r_total == $past(r_total) + CW'(1))
        else $error("insert did not count");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !s_axis_tready) else $error("accept while busy");

endmodule

### hdl/psdt_lcg.sv
// scatter random draw unit: seed register, entropy mix and lcg step
module psdt_lcg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_mix,
    input  logic [31:0] i_entropy,
    input  logic        i_step,
    output logic [14:0] o_x
);
    import psdt_pkg::*;

    logic [31:0] r_seed;
    logic [31:0] n_seed;

    always_comb begin
        n_seed = r_seed * LcgMul + LcgInc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SeedRst;
        end else if (i_mix) begin
            r_seed <= r_seed ^ i_entropy;
        end else if (i_step) begin
            r_seed <= n_seed;
        end
    end

    assign o_x = n_seed[30:16];

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_mix && i_step)) else $error("mix and step together");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_mix) && !$past(i_step) && $past(i_rst_n) |-> $stable(r_seed))
        else $error("seed changed without a step");
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> r_seed[30:16] == $past(o_x)) else $error("draw mismatch");

endmodule

### verif/pattern_stamp_dedup_table_tb.sv
// testbench for the pattern stamp table: stamps, scatters and clears against a table model
`timescale 1ns / 1ps

module pattern_stamp_dedup_table_tb;
    import psdt_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // operation, cursor_col, cursor_row, glyph, entropy, zero fill
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // placed_col, placed_row, placed_half, placed_glyph, entry_count, zero fill
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;

    pattern_stamp_dedup_table dut (.*);

    always #10 i_clk = ~i_clk;

    typedef struct packed {
        logic [15:0] col;
        logic [15:0] row;
        logic        half;
        logic [7:0]  glyph;
        logic [9:0]  count;
        logic        last;
    } t_placed;

    // table model
    logic [15:0] tbl_col[TableDepth];
    logic [15:0] tbl_row[TableDepth];
    logic        tbl_half[TableDepth];
    int          tbl_total = 0;
    logic [31:0] lcg_seed = SeedRst;

    t_placed placed_q[$];
    int      n_err = 0;
    int      n_cmds = 0;
    int      n_results = 0;
    bit      calm = 1'b0;   // no idling on either side

    task automatic report(input string what);
        n_err++;
        $display("mismatch: %s", what);
    endtask

    function automatic bit place_entry(input logic [15:0] c, input logic [15:0] r,
                                       input logic h, input logic [7:0] g);
        t_placed p;
        for (int i = 0; i < tbl_total; i++)
            if (tbl_col[i] == c && tbl_row[i] == r && tbl_half[i] == h) return 1'b0;
        if (tbl_total >= TableDepth) return 1'b0;
        tbl_col[tbl_total] = c;
        tbl_row[tbl_total] = r;
        tbl_half[tbl_total] = h;
        tbl_total++;
        p = '{c, r, h, g, 10'(tbl_total), 1'b0};
        placed_q.push_back(p);
        return 1'b1;
    endfunction

    function automatic logic [14:0] next_draw();
        lcg_seed = lcg_seed * LcgMul + LcgInc;
        return lcg_seed[30:16];
    endfunction

    function automatic void predict_command(input logic [2:0] op, input logic [15:0] cc,
                                            input logic [15:0] cr, input logic [7:0] g,
                                            input logic [31:0] ent);
        int dc[12] = '{0, 0, -1, 1, 0, 0, -1, 1, -1, 1, -2, 2};
        int dr[12] = '{0, 0, 0, 0, -1, 1, -1, -1, 1, 1, 0, 0};
        bit hf[12] = '{0, 1, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0};
        int tdc[4] = '{0, 0, 1, 0};
        int tdr[4] = '{0, 0, 0, 1};
        bit thf[4] = '{0, 1, 0, 1};
        int n;
        int left;
        int xc;
        int xr;
        bit xh;
        t_placed st;
        case (op)
            OP_CLEAR: begin
                tbl_total = 0;
            end
            OP_RING, OP_STAR: begin
                n = (op == OP_RING) ? 6 : 12;
                for (int i = 0; i < n; i++)
                    void'(place_entry(cc + 16'(dc[i]), cr + 16'(dr[i]), hf[i], g));
            end
            OP_LINE: begin
                for (int i = 0; i < 8; i++)
                    void'(place_entry(cc + 16'(i / 2), cr, 1'(i % 2), g));
            end
            OP_TRI: begin
                for (int i = 0; i < 4; i++)
                    void'(place_entry(cc + 16'(tdc[i]), cr + 16'(tdr[i]), thf[i], g));
            end
            OP_SCATTER: begin
                left = ScatterTarget;
                lcg_seed ^= ent;
                for (int t = 0; t < ScatterTries && left > 0; t++) begin
                    xc = (int'(next_draw()) * 9) / 32767 - 4;
                    xr = (int'(next_draw()) * 9) / 32767 - 4;
                    xh = next_draw() >= 15'd16384;
                    if (place_entry(cc + 16'(xc), cr + 16'(xr), xh, g)) left--;
                end
            end
            default: begin
            end
        endcase
        st = '{16'd0, 16'd0, 1'b0, 8'd0, 10'(tbl_total), 1'b1};
        placed_q.push_back(st);
    endfunction

    task automatic send_command(input logic [2:0] op, input logic [15:0] cc,
                                input logic [15:0] cr, input logic [7:0] g,
                                input logic [31:0] ent);
        while (!calm && $urandom_range(99) < 19) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata <= {5'd0, ent, g, cr, cc, op};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_command(op, cc, cr, g, ent);
        n_cmds++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_placed got;
        t_placed want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[32],
                   m_axis_tdata[40:33], m_axis_tdata[50:41], m_axis_tlast};
            n_results++;
            if (placed_q.size() == 0) begin
                report($sformatf("unexpected item %h", got));
            end else begin
                want = placed_q.pop_front();
                if (got.col != want.col) report($sformatf("col %h vs %h", got.col, want.col));
                if (got.row != want.row) report($sformatf("row %h vs %h", got.row, want.row));
                if (got.half != want.half) report("half differs");
                if (got.glyph != want.glyph)
                    report($sformatf("glyph %h vs %h", got.glyph, want.glyph));
                if (got.count != want.count)
                    report($sformatf("count %0d vs %0d", got.count, want.count));
                if (got.last != want.last) report("last differs");
            end
        end
        m_axis_tready <= calm || ($urandom_range(99) >= 19);
    end

    function automatic logic [15:0] rand_coord();
        return 16'($signed($urandom_range(64000)) - 32000);
    endfunction

    task automatic test_directed();
        logic [2:0] ops[6] = '{OP_RING, OP_LINE, OP_STAR, OP_TRI, OP_SCATTER, OP_CLEAR};
        foreach (ops[i]) send_command(ops[i], 16'd10, -16'sd5, 8'hA5, 32'h0);
        // wrap at both coordinate extremes, duplicates overlap
        send_command(OP_STAR, 16'sd32767, 16'h8000, 8'hFF, 32'hFFFF_FFFF);
        send_command(OP_RING, 16'sd32767, 16'h8000, 8'h00, 32'h0);
        send_command(OP_SCATTER, -16'sd32000, 16'sd32000, 8'h5A, 32'hFFFF_FFFF);
        send_command(OP_SCATTER, 16'sd32000, -16'sd32000, 8'h81, 32'hDEAD_BEEF);
        send_command(3'd6, 16'd1, 16'd1, 8'h11, 32'h1);
        send_command(3'd7, -16'sd1, -16'sd1, 8'h22, 32'h2);
        send_command(OP_TRI, 16'd0, 16'd0, 8'h01, 32'h0);
        send_command(OP_CLEAR, 16'd0, 16'd0, 8'h0, 32'h0);
    endtask

    // fill past capacity: distant star stamps never collide
    task automatic test_table_full();
        for (int i = 0; i < 44; i++)
            send_command(OP_STAR, 16'(i * 8), 16'd100, 8'(i), 32'h0);
        send_command(OP_SCATTER, 16'd0, 16'd0, 8'h33, $urandom());
        send_command(OP_STAR, 16'd2000, 16'd2000, 8'h44, 32'h0);
        send_command(OP_CLEAR, 16'd0, 16'd0, 8'h0, 32'h0);
    endtask

    task automatic test_random(input int n);
        logic [2:0] op;
        logic [15:0] cc;
        logic [15:0] cr;
        for (int i = 0; i < n; i++) begin
            calm = (i >= n / 3 && i < n / 2);
            op = ($urandom_range(29) == 0) ? OP_CLEAR : 3'($urandom_range(7));
            // mostly a small neighborhood so patterns overlap
            cc = ($urandom_range(3) == 0) ? rand_coord() : 16'($signed($urandom_range(12)) - 6);
            cr = ($urandom_range(3) == 0) ? rand_coord() : 16'($signed($urandom_range(12)) - 6);
            send_command(op, cc, cr, 8'($urandom()), $urandom());
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_table_full();
        test_random(40);
        s_axis_tvalid <= 1'b0;
        while (placed_q.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        $display("%0d commands sent, %0d result items checked", n_cmds, n_results);
        $display("covered every operation, wraparound, overlaps and a full table");
        if (n_err == 0 && placed_q.size() == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    initial begin
        #400ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

### sim.f
hdl/psdt_pkg.sv
hdl/psdt_lcg.sv
hdl/pattern_stamp_dedup_table.sv
verif/pattern_stamp_dedup_table_tb.sv
